// ===== hw/rtl/kjd_pkg.sv =====
// Shared constants, decoder state type and scan-code mapping for the byte decoder.
`timescale 1ns / 1ps
package kjd_pkg;

   localparam int ByteWidth = 8;
   localparam int MaskWidth = 6;
   localparam int DropWidth = 2;

   // Link header bytes and scan-code byte masks
   localparam logic [ByteWidth-1:0] HDR_JOY   = 8'hFF;
   localparam logic [ByteWidth-1:0] HDR_MASK  = 8'hF8;
   localparam logic [ByteWidth-1:0] BREAK_BIT = 8'h80;
   localparam logic [ByteWidth-1:0] CODE_MASK = 8'h7F;

   // Scan codes, break bit stripped
   localparam logic [ByteWidth-2:0] CODE_UP    = 7'h48;
   localparam logic [ByteWidth-2:0] CODE_DOWN  = 7'h50;
   localparam logic [ByteWidth-2:0] CODE_LEFT  = 7'h4B;
   localparam logic [ByteWidth-2:0] CODE_RIGHT = 7'h4D;
   localparam logic [ByteWidth-2:0] CODE_SPACE = 7'h39;
   localparam logic [ByteWidth-2:0] CODE_F1    = 7'h3B;
   localparam logic [ByteWidth-2:0] CODE_ESC   = 7'h01;

   // Key mask bit positions
   localparam logic [MaskWidth-1:0] BIT_UP    = 6'h01;
   localparam logic [MaskWidth-1:0] BIT_DOWN  = 6'h02;
   localparam logic [MaskWidth-1:0] BIT_LEFT  = 6'h04;
   localparam logic [MaskWidth-1:0] BIT_RIGHT = 6'h08;
   localparam logic [MaskWidth-1:0] BIT_FIRE  = 6'h10;
   localparam logic [MaskWidth-1:0] BIT_QUIT  = 6'h20;

   localparam logic [DropWidth-1:0] DROP_AFTER_FIRE_HDR = 2'd2;

   typedef struct packed {
      logic                 joy_expected;
      logic [DropWidth-1:0] drop_cnt;
      logic [MaskWidth-1:0] key_mask;
   } dec_state_type;

   function automatic logic [MaskWidth-1:0] code_to_bit(input logic [ByteWidth-2:0] code);
      logic [MaskWidth-1:0] bit_sel;
      unique case (code)
         CODE_UP:    bit_sel = BIT_UP;
         CODE_DOWN:  bit_sel = BIT_DOWN;
         CODE_LEFT:  bit_sel = BIT_LEFT;
         CODE_RIGHT: bit_sel = BIT_RIGHT;
         CODE_ESC:   bit_sel = BIT_QUIT;
         CODE_SPACE: bit_sel = BIT_FIRE;
         default:    bit_sel = '0;
      endcase
      return bit_sel;
   endfunction

endpackage

// ===== hw/rtl/kjd_decode.sv =====
// Next-state and pulse decode for one received link byte.
`timescale 1ns / 1ps
module kjd_decode
   import kjd_pkg::*;
(
   input  dec_state_type        state_cur,
   input  logic [ByteWidth-1:0] rx_byte,
   output dec_state_type        state_nxt,
   output logic                 rate_toggle
);

   logic [ByteWidth-2:0] code;
   logic                 brk;
   logic [MaskWidth-1:0] key_bit;
   logic [MaskWidth-1:0] joy_mask;

   assign code    = rx_byte[ByteWidth-2:0] & CODE_MASK[ByteWidth-2:0];
   assign brk     = |(rx_byte & BREAK_BIT);
   assign key_bit = code_to_bit(code);

   // Vertical sense is swapped in the stick report
   assign joy_mask = ({MaskWidth{rx_byte[0]}} & BIT_DOWN)
                   | ({MaskWidth{rx_byte[1]}} & BIT_UP)
                   | ({MaskWidth{rx_byte[2]}} & BIT_LEFT)
                   | ({MaskWidth{rx_byte[3]}} & BIT_RIGHT)
                   | ({MaskWidth{rx_byte[7]}} & BIT_FIRE);

   always_comb begin
      state_nxt   = state_cur;
      rate_toggle = 1'b0;
      priority if (state_cur.joy_expected) begin
         state_nxt.key_mask     = (state_cur.key_mask & BIT_QUIT) | joy_mask;
         state_nxt.joy_expected = 1'b0;
      end else if (state_cur.drop_cnt != '0) begin
         state_nxt.drop_cnt = state_cur.drop_cnt - DropWidth'(1);
      end else if (rx_byte == HDR_JOY) begin
         state_nxt.joy_expected = 1'b1;
      end else if ((rx_byte & HDR_MASK) == HDR_MASK) begin
         if (|rx_byte[1:0]) begin
            state_nxt.key_mask = state_cur.key_mask | BIT_FIRE;
         end else begin
            state_nxt.key_mask = state_cur.key_mask & ~BIT_FIRE;
         end
         state_nxt.drop_cnt = DROP_AFTER_FIRE_HDR;
      end else begin
         rate_toggle = brk && (code == CODE_F1);
         if (brk) begin
            state_nxt.key_mask = state_cur.key_mask & ~key_bit;
         end else begin
            state_nxt.key_mask = state_cur.key_mask | key_bit;
         end
      end
   end

endmodule

// ===== hw/rtl/keyboard_joystick_byte_decoder.sv =====
// Top level: input register, byte decode and result register with held-key state.
//
// Usage:
//   req_valid/req_ready/req_rx_byte carry one byte from the keyboard link per item.
//   rsp_valid/rsp_ready/rsp_held_keys/rsp_rate_toggle return one result per byte:
//   the held-key mask after that byte and a one-item pulse on an F1 release.
//   An accepted byte passes through the input register, then the result register,
//   before its result shows on rsp_valid, when the result side is free.
//   Throughput: one item per cycle unless the receiver stalls, set by the
//   single decode stage between the two registers; the decoder state is
//   updated in the same cycle it is read. When the receiver stalls, the result
//   register holds and the input register still takes one more byte; req_ready
//   drops only when both are full. Reset clears both valid flags, the held-key
//   mask, the pending drop count and the stick-report flag.
`timescale 1ns / 1ps
module keyboard_joystick_byte_decoder
   import kjd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ByteWidth-1:0] req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [MaskWidth-1:0] rsp_held_keys,
   output logic                 rsp_rate_toggle
);

   logic                 in_valid_ff;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 out_valid_ff;
   logic                 out_toggle_ff;
   dec_state_type        state_ff;
   dec_state_type        state_in;
   logic                 toggle_in;
   logic                 advance;
   logic                 take;

   kjd_decode u_decode (
      .state_cur   (state_ff),
      .rx_byte     (in_byte_ff),
      .state_nxt   (state_in),
      .rate_toggle (toggle_in)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_toggle_ff <= toggle_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_held_keys   = state_ff.key_mask;
   assign rsp_rate_toggle = out_toggle_ff;

endmodule

// ===== hw/rtl/kjd_checker.sv =====
// Port-level checker for the byte decoder, bound to the top level.
`timescale 1ns / 1ps
module kjd_checker
   import kjd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [MaskWidth-1:0] rsp_held_keys,
   input logic                 rsp_rate_toggle
);

   // Results are empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Backpressure on the input only when the result side is stalled
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without result stall");

   // A new result traces back to an accepted item, through the input and result registers
   a_rise_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without an accepted item");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_held_keys) && $stable(rsp_rate_toggle)))
      else $error("stalled result changed");

endmodule

bind keyboard_joystick_byte_decoder kjd_checker u_kjd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_held_keys   (rsp_held_keys),
   .rsp_rate_toggle (rsp_rate_toggle)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the keyboard/joystick byte decoder: directed, then random.
module tb_top;
   import kjd_pkg::*;

   localparam int DirectedItems = 25;
   localparam int RandomItems   = 525;
   localparam int MaxIdle       = 13;
   localparam int HoldOffAt     = 200;
   localparam int HoldOffCycles = 80;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 10;
   localparam int MaxReports    = 10;
   localparam int ResetCycles   = 5;

   typedef struct {
      logic [ByteWidth-1:0] data;
      bit                   typed;
      logic [MaskWidth-1:0] keys;
      logic                 pulse;
   } byte_row_type;

   typedef struct {
      logic [MaskWidth-1:0] keys;
      logic                 pulse;
   } key_report_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic [ByteWidth-1:0] req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [MaskWidth-1:0] rsp_held_keys;
   logic                 rsp_rate_toggle;

   byte_row_type   byte_rows[$];
   key_report_type expected_reports[$];
   int unsigned mismatches  = 0;
   int unsigned idle_cycles = 0;

   // Predicted decoder state
   logic                 stick_next = 1'b0;
   logic [DropWidth-1:0] drop_left  = '0;
   logic [MaskWidth-1:0] held_now   = '0;

   keyboard_joystick_byte_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_held_keys  (rsp_held_keys),
      .rsp_rate_toggle(rsp_rate_toggle)
   );

   always #4 clock = ~clock;

   task automatic add_row(input logic [ByteWidth-1:0] data, input bit typed,
                          input logic [MaskWidth-1:0] keys, input logic pulse);
      byte_row_type row;
      row.data  = data;
      row.typed = typed;
      row.keys  = keys;
      row.pulse = pulse;
      byte_rows.push_back(row);
   endtask

   // Advance the predicted state by one byte and return the held keys and F1 pulse it leaves
   task automatic decode_byte(input logic [ByteWidth-1:0] b, output key_report_type r);
      logic [MaskWidth-1:0] stick;
      logic [MaskWidth-1:0] key_bit;
      logic [ByteWidth-2:0] code;
      r.pulse = 1'b0;
      code    = b[ByteWidth-2:0];
      if (stick_next) begin
         stick = '0;
         if (b[0]) stick |= BIT_DOWN;
         if (b[1]) stick |= BIT_UP;
         if (b[2]) stick |= BIT_LEFT;
         if (b[3]) stick |= BIT_RIGHT;
         if (b[7]) stick |= BIT_FIRE;
         held_now   = (held_now & BIT_QUIT) | stick;
         stick_next = 1'b0;
      end else if (drop_left != '0) begin
         drop_left = drop_left - 1'b1;
      end else if (b == HDR_JOY) begin
         stick_next = 1'b1;
      end else if ((b & HDR_MASK) == HDR_MASK) begin
         if (b[1:0] != 2'b00) held_now |= BIT_FIRE;
         else held_now &= ~BIT_FIRE;
         drop_left = DROP_AFTER_FIRE_HDR;
      end else begin
         case (code)
            CODE_UP:    key_bit = BIT_UP;
            CODE_DOWN:  key_bit = BIT_DOWN;
            CODE_LEFT:  key_bit = BIT_LEFT;
            CODE_RIGHT: key_bit = BIT_RIGHT;
            CODE_SPACE: key_bit = BIT_FIRE;
            CODE_ESC:   key_bit = BIT_QUIT;
            default:    key_bit = '0;
         endcase
         r.pulse = (code == CODE_F1) && b[7];
         if (b[7]) held_now &= ~key_bit;
         else held_now |= key_bit;
      end
      r.keys = held_now;
   endtask

   // Every fourth window of 40 items runs back to back
   function automatic int unsigned draw_idle(input int unsigned n);
      return ((n / 40) % 4 == 3) ? 0 : $urandom_range(0, MaxIdle);
   endfunction

   initial begin
      key_report_type       r;
      int unsigned          gap;
      int unsigned          kind;
      logic [ByteWidth-1:0] b;

      // Make every mapped key, F1 make and break, then release up
      add_row(8'h48, 1'b1, 6'h01, 1'b0);
      add_row(8'h50, 1'b1, 6'h03, 1'b0);
      add_row(8'h4B, 1'b1, 6'h07, 1'b0);
      add_row(8'h4D, 1'b1, 6'h0F, 1'b0);
      add_row(8'h39, 1'b1, 6'h1F, 1'b0);
      add_row(8'h01, 1'b1, 6'h3F, 1'b0);
      add_row(8'h3B, 1'b1, 6'h3F, 1'b0);
      add_row(8'hBB, 1'b1, 6'h3F, 1'b1);
      add_row(8'hC8, 1'b1, 6'h3E, 1'b0);
      // Unmapped make and break
      add_row(8'h00, 1'b0, '0, 1'b0);
      add_row(8'h80, 1'b0, '0, 1'b0);
      // Stick report of all ones is not a header; upper report bits ignored
      add_row(8'hFF, 1'b1, 6'h3E, 1'b0);
      add_row(8'hFF, 1'b1, 6'h3F, 1'b0);
      add_row(8'hFF, 1'b0, '0, 1'b0);
      add_row(8'h70, 1'b1, 6'h20, 1'b0);
      // Fire header clearing fire, then dropped header and F1 break
      add_row(8'hF8, 1'b1, 6'h20, 1'b0);
      add_row(8'hFF, 1'b1, 6'h20, 1'b0);
      add_row(8'hBB, 1'b1, 6'h20, 1'b0);
      add_row(8'hFE, 1'b1, 6'h30, 1'b0);
      add_row(8'h48, 1'b0, '0, 1'b0);
      add_row(8'hFF, 1'b0, '0, 1'b0);
      add_row(8'h81, 1'b1, 6'h10, 1'b0);
      add_row(8'hFF, 1'b0, '0, 1'b0);
      add_row(8'h00, 1'b1, 6'h00, 1'b0);
      add_row(8'hBB, 1'b1, 6'h00, 1'b1);

      while (byte_rows.size() < DirectedItems + RandomItems) begin
         kind = $urandom_range(0, 9);
         if (kind <= 4) begin
            case ($urandom_range(0, 7))
               0:       b[6:0] = CODE_UP;
               1:       b[6:0] = CODE_DOWN;
               2:       b[6:0] = CODE_LEFT;
               3:       b[6:0] = CODE_RIGHT;
               4:       b[6:0] = CODE_SPACE;
               5:       b[6:0] = CODE_ESC;
               6:       b[6:0] = CODE_F1;
               default: b[6:0] = 7'($urandom_range(0, 127));
            endcase
            b[7] = 1'($urandom_range(0, 1));
            add_row(b, 1'b0, '0, 1'b0);
         end else if (kind <= 6) begin
            add_row(HDR_JOY, 1'b0, '0, 1'b0);
            add_row(8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
         end else if (kind == 7) begin
            add_row(8'($urandom_range(8'hF8, 8'hFE)), 1'b0, '0, 1'b0);
            repeat (2) begin
               b = ($urandom_range(0, 3) == 0) ? HDR_JOY : 8'($urandom_range(0, 255));
               add_row(b, 1'b0, '0, 1'b0);
            end
         end else begin
            add_row(8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
         end
      end

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < byte_rows.size(); i++) begin
         gap = draw_idle(i);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_rx_byte <= byte_rows[i].data;
         do @(posedge clock); while (!(req_valid && req_ready));
         decode_byte(byte_rows[i].data, r);
         if (byte_rows[i].typed) begin
            r.keys  = byte_rows[i].keys;
            r.pulse = byte_rows[i].pulse;
         end
         expected_reports.push_back(r);
      end
      req_valid <= 1'b0;

      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off so the input backs up
   initial begin
      int unsigned    wait_cycles;
      int unsigned    got;
      key_report_type want;
      got = 0;
      repeat (ResetCycles) @(posedge clock);
      forever begin
         wait_cycles = (got == HoldOffAt) ? HoldOffCycles : draw_idle(got);
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         got++;
         if (expected_reports.size() == 0) begin
            if (mismatches < MaxReports)
               $display("item %0d: unexpected result keys=%h pulse=%b",
                        got, rsp_held_keys, rsp_rate_toggle);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_held_keys !== want.keys || rsp_rate_toggle !== want.pulse) begin
               if (mismatches < MaxReports)
                  $display("item %0d: expected keys=%h pulse=%b, got keys=%h pulse=%b",
                           got, want.keys, want.pulse, rsp_held_keys, rsp_rate_toggle);
               mismatches++;
            end
         end
      end
   end

   // Stop a hung run: count cycles in which neither side moves an item
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
hw/rtl/kjd_pkg.sv
hw/rtl/kjd_decode.sv
hw/rtl/keyboard_joystick_byte_decoder.sv
hw/rtl/kjd_checker.sv
test/tb_top.sv
